/* sv/modinv_pkg.sv */
// ----------------------------------------------------------------------------
// modinv_pkg
// Shared types for the modular inverse core: request and result payloads,
// controller states and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package modinv_pkg;

  localparam int unsigned FieldW = 32;

  typedef struct packed {
    logic [FieldW-1:0] modulus;
    logic [FieldW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [FieldW-1:0] inverse;
    logic              no_inverse;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LOADB,
    ST_CHECK,
    ST_DIVIDE,
    ST_UPDATE,
    ST_FINISH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;      // capture a new request
    logic red_step;  // one bit of the value mod modulus division
    logic load_b;    // take the reduced value as divisor
    logic div_init;  // set up a division of a by b
    logic div_step;  // one quotient bit, with coefficient accumulation
    logic update;    // shift the remainder sequence and coefficients
    logic finish;    // form the result
  } cmd_t;

  typedef struct packed {
    logic m_zero;
    logic b_zero;
  } sts_t;

endpackage

/* sv/modular_inverse_ext_euclid_core.sv */
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_core
// Modular inverse by the extended Euclidean algorithm.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on res_o for the single cycle in which done_o is high and must be taken
// then, as the core cannot be held off. The value is first reduced modulo
// the modulus, then each Euclid step runs the shared restoring divider at
// one bit per cycle and passes through a check and an update state; at
// WIDTH = 32 the worst case is about 46 division steps. A new request may
// be issued in the same cycle as done_o. A zero modulus skips the
// arithmetic and goes through the finish and done states to no_inverse.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_core import modinv_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output res_t res_o
);

  cmd_t cmd;
  sts_t sts;

  modinv_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  modinv_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i (clk_i),
    .req_i (req_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .res_o (res_o)
  );

endmodule

/* sv/modinv_ctrl.sv */
// ----------------------------------------------------------------------------
// modinv_ctrl
// Sequencer for the modular inverse core: walks the reduction, the Euclid
// division steps and the result phase, and counts bits of each division.
// ----------------------------------------------------------------------------
module modinv_ctrl import modinv_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o,
  output logic done_o
);

  localparam int unsigned CntW = $clog2(WIDTH);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            last_bit;

  assign last_bit = (cnt_q == CntW'(WIDTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE, ST_DONE: begin
        if (start_i) begin
          // a zero modulus has no inverse, skip the arithmetic
          state_d = sts_i.m_zero ? ST_FINISH : ST_REDUCE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_REDUCE: if (last_bit) state_d = ST_LOADB;
      ST_LOADB:  state_d = ST_CHECK;
      ST_CHECK:  state_d = sts_i.b_zero ? ST_FINISH : ST_DIVIDE;
      ST_DIVIDE: if (last_bit) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_CHECK;
      ST_FINISH: state_d = ST_DONE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = '0;
    if (state_q == ST_REDUCE || state_q == ST_DIVIDE) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o      = 1'b0;
        cmd_o.load  = start_i;
      end
      ST_DONE: begin
        busy_o      = 1'b0;
        done_o      = 1'b1;
        cmd_o.load  = start_i;
      end
      ST_REDUCE: cmd_o.red_step = 1'b1;
      ST_LOADB:  cmd_o.load_b   = 1'b1;
      ST_CHECK:  cmd_o.div_init = ~sts_i.b_zero;
      ST_DIVIDE: cmd_o.div_step = 1'b1;
      ST_UPDATE: cmd_o.update   = 1'b1;
      ST_FINISH: cmd_o.finish   = 1'b1;
      default:   cmd_o          = '0;
    endcase
  end

endmodule

/* sv/modinv_dp.sv */
// ----------------------------------------------------------------------------
// modinv_dp
// Datapath for the modular inverse core: a radix-2 restoring divider shared
// by the reduction and the Euclid steps, a shift-add accumulator for the
// quotient times coefficient product, and the result formation.
// ----------------------------------------------------------------------------
module modinv_dp import modinv_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic clk_i,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output res_t res_o
);

  logic [63:0]      m_ext, v_ext, inv_ext;
  logic [WIDTH-1:0] m_in, v_in;

  logic [WIDTH-1:0] m_q, a_q, b_q, up_q, uc_q, rem_q, dq_q, acc_q;
  logic             odd_q;
  res_t             res_q;

  logic [WIDTH:0]   rem_sh, rem_sub;
  logic             q_bit;
  logic [WIDTH-1:0] rem_nx, acc_nx, neg_up, inv;

  assign m_ext = 64'(req_i.modulus);
  assign v_ext = 64'(req_i.value);
  assign m_in  = m_ext[WIDTH-1:0];
  assign v_in  = v_ext[WIDTH-1:0];

  // one restoring division step, quotient bits come out msb first
  assign rem_sh  = {rem_q, dq_q[WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, b_q};
  assign q_bit   = (rem_sh >= {1'b0, b_q});
  assign rem_nx  = q_bit ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
  // partial products never exceed the final coefficient, which never exceeds m
  assign acc_nx  = {acc_q[WIDTH-2:0], 1'b0} + (q_bit ? uc_q : '0);

  always_comb begin
    neg_up = m_q - up_q;
    inv    = (odd_q || up_q == '0) ? up_q : neg_up;
    if (inv >= m_q) begin
      inv = '0;
    end
    if (a_q != WIDTH'(1)) begin
      inv = '0;
    end
  end

  assign inv_ext = 64'(inv);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q   <= m_in;
      a_q   <= m_in;
      b_q   <= m_in;
      dq_q  <= v_in;
      rem_q <= '0;
      up_q  <= '0;
      uc_q  <= WIDTH'(1);
      odd_q <= 1'b0;
    end
    if (cmd_i.red_step) begin
      rem_q <= rem_nx;
      dq_q  <= {dq_q[WIDTH-2:0], q_bit};
    end
    if (cmd_i.load_b) begin
      b_q <= rem_q;
    end
    if (cmd_i.div_init) begin
      dq_q  <= a_q;
      rem_q <= '0;
      acc_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_nx;
      dq_q  <= {dq_q[WIDTH-2:0], q_bit};
      acc_q <= acc_nx;
    end
    if (cmd_i.update) begin
      a_q   <= b_q;
      b_q   <= rem_q;
      up_q  <= uc_q;
      uc_q  <= up_q + acc_q;
      odd_q <= ~odd_q;
    end
    if (cmd_i.finish) begin
      res_q.inverse    <= inv_ext[FieldW-1:0];
      res_q.no_inverse <= (a_q != WIDTH'(1));
    end
  end

  assign sts_o.m_zero = (m_in == '0);
  assign sts_o.b_zero = (b_q == '0);
  assign res_o        = res_q;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the modular inverse core against an extended Euclid predictor:
// directed corner requests, then random ones, with random gaps between requests.
// ----------------------------------------------------------------------------
module testbench;
  import modinv_pkg::*;

  localparam int unsigned NumRandom = 400;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 100;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  res_t res_o;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int unsigned gap_left;
  int unsigned idle_cycles;
  int unsigned mismatch_count;

  modular_inverse_ext_euclid_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // extended Euclid with the coefficient held as magnitude plus step parity
  function automatic res_t predict_inverse(req_t r);
    logic [63:0] m, a, b, u_prev, u_cur, u_next, q, rem, inv;
    bit odd;
    res_t res;
    m = 64'(r.modulus);
    res.inverse = '0;
    res.no_inverse = 1'b1;
    if (m == 0) begin
      return res;
    end
    a = m;
    b = 64'(r.value) % m;
    u_prev = 0;
    u_cur = 1;
    odd = 1'b0;
    while (b != 0) begin
      q = a / b;
      rem = a % b;
      u_next = u_prev + q * u_cur;
      a = b;
      b = rem;
      u_prev = u_cur;
      u_cur = u_next;
      odd = !odd;
    end
    if (a != 1) begin
      return res;
    end
    if (odd || u_prev == 0) begin
      inv = u_prev;
    end else begin
      inv = m - u_prev;
    end
    if (inv >= m) begin
      inv = 0;
    end
    res.inverse = inv[FieldW-1:0];
    res.no_inverse = 1'b0;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end else if (roll < 88) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 150);
  endfunction

  task automatic report_mismatch(string what, logic [FieldW-1:0] got, logic [FieldW-1:0] want);
    $display("%0t: mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_request(logic [FieldW-1:0] modulus, logic [FieldW-1:0] value);
    req_t r;
    r.modulus = modulus;
    r.value = value;
    pending_reqs.push_back(r);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
      gap_left <= 0;
    end else if (start && busy) begin
      // hold the request until the core takes it
    end else begin
      if (start) begin
        expected_results.push_back(predict_inverse(req_i));
      end
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
        req_i <= {$urandom, $urandom};
      end else if (pending_reqs.size() != 0) begin
        req_i <= pending_reqs.pop_front();
        start <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", res_o.inverse, '0);
      end else begin
        if (res_o.inverse !== expected_results[0].inverse) begin
          report_mismatch("inverse", res_o.inverse, expected_results[0].inverse);
        end
        if (res_o.no_inverse !== expected_results[0].no_inverse) begin
          report_mismatch("no_inverse", FieldW'(res_o.no_inverse),
                          FieldW'(expected_results[0].no_inverse));
        end
        void'(expected_results.pop_front());
      end
    end
  end

  // cycles with neither a request nor a result taken
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [FieldW-1:0] m, v;
    int unsigned kind;
    idle_cycles = 0;
    mismatch_count = 0;

    // directed corners
    queue_request(32'd1, 32'd0);
    queue_request(32'd1, 32'hFFFF_FFFF);
    queue_request(32'hFFFF_FFFF, 32'd0);
    queue_request(32'hFFFF_FFFF, 32'd1);
    queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(32'd0, 32'd5);
    queue_request(32'd0, 32'd0);
    queue_request(32'd2, 32'd1);
    queue_request(32'd2, 32'd3);
    queue_request(32'd7, 32'd14);
    queue_request(32'd7, 32'd3);
    queue_request(32'd7, 32'd6);
    queue_request(32'd10, 32'd4);
    queue_request(32'd13, 32'd100);
    queue_request(32'd2971215073, 32'd1836311903);  // consecutive fibonacci, longest run
    queue_request(32'd1836311903, 32'd2971215073);
    queue_request(32'hFFFF_FFFB, 32'd2);
    queue_request(32'h8000_0000, 32'hFFFF_FFFF);
    queue_request(32'h8000_0000, 32'h4000_0000);
    queue_request(32'hAAAA_AAAA, 32'h5555_5555);

    for (int i = 0; i < NumRandom; i++) begin
      kind = $urandom_range(0, 99);
      m = $urandom >> $urandom_range(0, 31);
      if (m == 0) begin
        m = 32'd1;
      end
      v = $urandom;
      if (kind < 10) begin
        m = $urandom_range(1, 1000);
      end else if (kind < 18) begin
        v = m * $urandom_range(0, 5);
      end else if (kind < 21) begin
        m = 32'd1;
      end else if (kind < 23) begin
        m = 32'd0;
      end else if (kind < 30) begin
        v = v >> $urandom_range(0, 31);
      end else if (kind < 36) begin
        m = m | 32'h8000_0000;
      end
      queue_request(m, v);
    end

    do begin
      @(posedge clk_i);
      #1;
    end while (!rst_ni || start || pending_reqs.size() != 0 || expected_results.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
